// ----- hdl/hpwsm_pkg.sv -----
`default_nettype none

package hpwsm_pkg;

  // Result and divider widths
  localparam int unsigned RpmW = 16;
  localparam int unsigned DenW = 40;

  localparam logic [RpmW-1:0] RpmNumerator = 16'd60000;
  localparam logic [7:0]      PercentBase  = 8'd100;

  // Configuration register map (word index)
  typedef enum logic [2:0] {
    CfgMagnetCount    = 3'd0,
    CfgMinInterval    = 3'd1,
    CfgDebouncePct    = 3'd2,
    CfgStopTimeout    = 3'd3,
    CfgStopMultiplier = 3'd4
  } cfg_idx_e;

  // Reset values
  localparam logic [7:0]  MagnetCountRst    = 8'd20;
  localparam logic [15:0] MinIntervalRst    = 16'd1;
  localparam logic [6:0]  DebouncePctRst    = 7'd50;
  localparam logic [15:0] StopTimeoutRst    = 16'd500;
  localparam logic [3:0]  StopMultiplierRst = 4'd3;

  // Handshake between the sequencer and the serial divider
  typedef struct packed {
    logic            start;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [RpmW-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/hpwsm_div.sv -----
`default_nettype none

// Restoring divider: constant numerator over a wide divisor, one quotient bit
// per cycle, MSB first. Divisor must be nonzero.
module hpwsm_div (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  hpwsm_pkg::div_req_t   req_i,
  output hpwsm_pkg::div_rsp_t   rsp_o
);

  localparam int unsigned RpmW = hpwsm_pkg::RpmW;
  localparam int unsigned DenW = hpwsm_pkg::DenW;
  localparam int unsigned CntW = $clog2(RpmW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RpmW-1:0] rem_q, rem_d;
  logic [RpmW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d;

  logic [RpmW:0]   trial;
  logic [RpmW-1:0] trial_sub;
  logic            take;

  always_comb begin
    trial     = {rem_q, hpwsm_pkg::RpmNumerator[cnt_q]};
    take      = {{(DenW-RpmW-1){1'b0}}, trial} >= den_q;
    // remainder after a take stays below the numerator, so 16 bits suffice
    trial_sub = trial[RpmW-1:0] - den_q[RpmW-1:0];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(RpmW - 1);
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = take ? trial_sub : trial[RpmW-1:0];
      quo_d = {quo_q[RpmW-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// ----- hdl/hall_pulse_wheel_speed_meter_unit.sv -----
`default_nettype none

// Channel   Dir  Handshake              Payload
// -------   ---  ---------------------  ---------------------------------------
// in        in   in_valid_i/in_stall_o  opcode_i, now_ms_i
// out       out  out_valid_o/out_stall_i wheel_rpm_o, pulse_accepted_o,
//                                       stop_declared_o
// cfg       in   APB psel/penable/...   5 registers at paddr 4*i
//
// Steps to a valid result: poll S_PROD, S_QTEST, S_OUT; rejected pulse S_PROD,
//   S_SCALE, S_PTEST, S_OUT; accepted pulse also S_DENOM, S_DIV, S_WAIT (the
//   60000/denominator serial divider, one quotient bit per cycle) before S_OUT;
//   a pulse saturating on a zero divisor goes from S_DIV to S_OUT; a pulse or
//   poll with no reference goes straight to S_OUT. The next item can be taken in the cycle after the result is loaded.
// One item is in flight at a time; in_stall_o is high until its result is
//   loaded into the output register, which then waits for the downstream side.
// Reset (rst_ni low, async) clears the speed state and loads register defaults.
// A stalled result holds the sequencer in its last step, not the output.
module hall_pulse_wheel_speed_meter_unit (
  input  wire         clk_i,
  input  wire         rst_ni,

  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         opcode_i,
  input  wire  [31:0] now_ms_i,

  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] wheel_rpm_o,
  output logic        pulse_accepted_o,
  output logic        stop_declared_o,

  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RpmW = hpwsm_pkg::RpmW;
  localparam int unsigned DenW = hpwsm_pkg::DenW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,    // shared multiply: last_interval * percent or * multiplier
    S_SCALE,   // shared multiply: diff * 100
    S_PTEST,   // pulse debounce test
    S_QTEST,   // poll stop test
    S_DENOM,   // shared multiply: diff * magnet_count
    S_DIV,     // kick divider or saturate
    S_WAIT,
    S_OUT
  } state_e;

  // ---------------------------------------------------------------- config
  logic [7:0]  magnet_q;
  logic [15:0] min_int_q;
  logic [6:0]  pct_q;
  logic [15:0] stop_to_q;
  logic [3:0]  stop_mul_q;

  logic                  cfg_we;
  hpwsm_pkg::cfg_idx_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = hpwsm_pkg::cfg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magnet_q   <= hpwsm_pkg::MagnetCountRst;
      min_int_q  <= hpwsm_pkg::MinIntervalRst;
      pct_q      <= hpwsm_pkg::DebouncePctRst;
      stop_to_q  <= hpwsm_pkg::StopTimeoutRst;
      stop_mul_q <= hpwsm_pkg::StopMultiplierRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        hpwsm_pkg::CfgMagnetCount:    magnet_q   <= pwdata[7:0];
        hpwsm_pkg::CfgMinInterval:    min_int_q  <= pwdata[15:0];
        hpwsm_pkg::CfgDebouncePct:    pct_q      <= pwdata[6:0];
        hpwsm_pkg::CfgStopTimeout:    stop_to_q  <= pwdata[15:0];
        hpwsm_pkg::CfgStopMultiplier: stop_mul_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hpwsm_pkg::CfgMagnetCount:    prdata = {24'b0, magnet_q};
      hpwsm_pkg::CfgMinInterval:    prdata = {16'b0, min_int_q};
      hpwsm_pkg::CfgDebouncePct:    prdata = {25'b0, pct_q};
      hpwsm_pkg::CfgStopTimeout:    prdata = {16'b0, stop_to_q};
      hpwsm_pkg::CfgStopMultiplier: prdata = {28'b0, stop_mul_q};
      default:                      prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- datapath
  state_e          state_q;
  logic            op_q;        // 1 = poll
  logic [31:0]     now_q;
  logic [31:0]     diff_q;      // now - last pulse, mod 2^32
  logic [DenW-1:0] prod_q;      // interval * percent, or interval * multiplier
  logic [DenW-1:0] den_q;       // diff * 100, later diff * magnets

  logic            has_ref_q;
  logic [31:0]     last_time_q;
  logic [31:0]     last_int_q;
  logic [RpmW-1:0] speed_q;

  logic [RpmW-1:0] res_rpm_q;
  logic            res_acc_q;
  logic            res_stop_q;

  logic            out_valid_q;
  logic [RpmW-1:0] out_rpm_q;
  logic            out_acc_q;
  logic            out_stop_q;

  // Shared 32x8 multiplier, operands picked by the sequencer step
  logic [31:0]     mul_a;
  logic [7:0]      mul_b;
  logic [DenW-1:0] mul_p;

  always_comb begin
    mul_a = diff_q;
    mul_b = magnet_q;
    case (state_q)
      S_PROD: begin
        mul_a = last_int_q;
        mul_b = op_q ? {4'b0, stop_mul_q} : {1'b0, pct_q};
      end
      S_SCALE: mul_b = hpwsm_pkg::PercentBase;
      default: ;
    endcase
    mul_p = DenW'(mul_a) * DenW'(mul_b);
  end

  // Shared wide compare. Pulse: floor(P/100) <= diff  <=>  P < diff*100 + 100.
  logic [DenW:0] cmp_a;
  logic [DenW:0] cmp_b;
  logic          cmp_ge;

  always_comb begin
    if (op_q) begin
      cmp_a = {{(DenW-31){1'b0}}, diff_q};
      cmp_b = {1'b0, prod_q};
    end else begin
      cmp_a = {1'b0, prod_q};
      cmp_b = {1'b0, den_q} + (DenW+1)'(hpwsm_pkg::PercentBase);
    end
    cmp_ge = cmp_a >= cmp_b;
  end

  logic pulse_ok;
  logic stop_ok;

  assign pulse_ok = (diff_q >= {16'b0, min_int_q}) && ((last_int_q == '0) || !cmp_ge);
  assign stop_ok  = (diff_q >= {16'b0, stop_to_q}) && ((last_int_q == '0) || cmp_ge)
                    && (speed_q != '0);

  // Serial divider
  hpwsm_pkg::div_req_t div_req;
  hpwsm_pkg::div_rsp_t div_rsp;

  assign div_req.start = (state_q == S_DIV) && (den_q != '0);
  assign div_req.den   = den_q;

  hpwsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic out_free;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= 1'b0;
      now_q       <= '0;
      diff_q      <= '0;
      prod_q      <= '0;
      den_q       <= '0;
      has_ref_q   <= 1'b0;
      last_time_q <= '0;
      last_int_q  <= '0;
      speed_q     <= '0;
      res_rpm_q   <= '0;
      res_acc_q   <= 1'b0;
      res_stop_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_rpm_q   <= '0;
      out_acc_q   <= 1'b0;
      out_stop_q  <= 1'b0;
    end else begin
      // S_OUT reloads the output register on the same edge
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q       <= opcode_i;
            now_q      <= now_ms_i;
            diff_q     <= now_ms_i - last_time_q;
            res_rpm_q  <= speed_q;
            res_acc_q  <= 1'b0;
            res_stop_q <= 1'b0;
            if (has_ref_q) begin
              state_q <= S_PROD;
            end else begin
              // first pulse only records the reference; poll does nothing
              if (!opcode_i) begin
                has_ref_q   <= 1'b1;
                last_time_q <= now_ms_i;
              end
              state_q <= S_OUT;
            end
          end
        end
        S_PROD: begin
          prod_q  <= mul_p;
          state_q <= op_q ? S_QTEST : S_SCALE;
        end
        S_SCALE: begin
          den_q   <= mul_p;
          state_q <= S_PTEST;
        end
        S_PTEST: begin
          state_q <= pulse_ok ? S_DENOM : S_OUT;
        end
        S_QTEST: begin
          if (stop_ok) begin
            speed_q     <= '0;
            has_ref_q   <= 1'b0;
            last_time_q <= '0;
            last_int_q  <= '0;
            res_rpm_q   <= '0;
            res_stop_q  <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_DENOM: begin
          den_q   <= mul_p;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (den_q == '0) begin
            // zero divisor only with out-of-range registers: saturate
            speed_q     <= hpwsm_pkg::RpmNumerator;
            res_rpm_q   <= hpwsm_pkg::RpmNumerator;
            res_acc_q   <= 1'b1;
            last_int_q  <= diff_q;
            last_time_q <= now_q;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            speed_q     <= div_rsp.quo;
            res_rpm_q   <= div_rsp.quo;
            res_acc_q   <= 1'b1;
            last_int_q  <= diff_q;
            last_time_q <= now_q;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_rpm_q   <= res_rpm_q;
            out_acc_q   <= res_acc_q;
            out_stop_q  <= res_stop_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign wheel_rpm_o      = out_rpm_q;
  assign pulse_accepted_o = out_acc_q;
  assign stop_declared_o  = out_stop_q;

endmodule

`default_nettype wire
